// ----- rtl/hdlcenc_pkg.sv -----
// shared types, constants and crc function for the hdlc frame encoder
// no dependencies
package hdlcenc_pkg;

  localparam logic [7:0]  FlagByte   = 8'h7E;
  localparam logic [7:0]  EscapeByte = 8'h7D;
  localparam logic [7:0]  EscapeXor  = 8'h20;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] CrcInit    = 16'hFFFF;

  // one classified input byte, as handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        open;
    logic        last;
    logic [15:0] crc;
  } ent_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_OPEN,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_CLOSE
  } phase_e;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FlagByte) || (b == EscapeByte);
  endfunction

endpackage

// ----- rtl/hdlcenc_front.sv -----
// front end: accepts input bytes, tracks frame state and running crc
// depends on hdlcenc_pkg
module hdlcenc_front import hdlcenc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_frame_i,
  output ent_t       ent_o
);

  logic [15:0] crc_q, crc_d;
  logic        inside_q, inside_d;
  logic [15:0] crc_base;
  logic [15:0] crc_new;

  always_comb begin
    crc_base   = inside_q ? crc_q : CrcInit;
    crc_new    = crc_update(crc_base, data_byte_i);
    ent_o.data = data_byte_i;
    ent_o.open = !inside_q;
    ent_o.last = end_of_frame_i;
    ent_o.crc  = crc_new;
    crc_d      = crc_q;
    inside_d   = inside_q;
    if (accept_i) begin
      crc_d    = end_of_frame_i ? CrcInit : crc_new;
      inside_d = !end_of_frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CrcInit;
      inside_q <= 1'b0;
    end else begin
      crc_q    <= crc_d;
      inside_q <= inside_d;
    end
  end

endmodule

// ----- rtl/hdlcenc_queue.sv -----
// short queue of classified entries between front and back
// depends on hdlcenc_pkg
module hdlcenc_queue import hdlcenc_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ent_t ent_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output ent_t ent_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ent_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push_en, pop_en;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign ent_o   = mem_q[rd_q];
  assign push_en = push_i && !full_o;
  assign pop_en  = pop_i && valid_o;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_en) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_en) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_en, pop_en})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem_q[wr_q] <= ent_i;
    end
  end

endmodule

// ----- rtl/hdlcenc_back.sv -----
// back end: walks each entry through flag (if open), escaped data, crc and closing flag (if last)
// one line byte per cycle into the output register while it is free or popped; depends on hdlcenc_pkg
module hdlcenc_back import hdlcenc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  ent_t       ent_i,
  output logic       pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] line_byte_o,
  output logic       run_last_o,
  output logic       frame_done_o
);

  phase_e     phase_q, phase_d, phase_cur;
  logic       esc_q, esc_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       done_q, done_d;
  logic       step;
  logic [7:0] src;
  logic       has_src;

  assign empty_o      = !out_valid_q;
  assign line_byte_o  = byte_q;
  assign run_last_o   = last_q;
  assign frame_done_o = done_q;
  assign step         = valid_i && (!out_valid_q || pop_i);

  always_comb begin
    phase_cur = (phase_q == PH_START) ? (ent_i.open ? PH_OPEN : PH_DATA) : phase_q;
    phase_d   = phase_q;
    esc_d     = esc_q;
    byte_d    = byte_q;
    last_d    = 1'b0;
    done_d    = 1'b0;
    pop_o     = 1'b0;
    src       = ent_i.data;
    has_src   = 1'b0;
    out_valid_d = out_valid_q && !pop_i;

    unique case (phase_cur)
      PH_DATA:   begin src = ent_i.data;      has_src = 1'b1; end
      PH_CRC_LO: begin src = ent_i.crc[7:0];  has_src = 1'b1; end
      PH_CRC_HI: begin src = ent_i.crc[15:8]; has_src = 1'b1; end
      default:   begin src = FlagByte;        has_src = 1'b0; end
    endcase

    if (step) begin
      out_valid_d = 1'b1;
      if (has_src && !esc_q && needs_esc(src)) begin
        // first half of an escape pair
        byte_d    = EscapeByte;
        esc_d     = 1'b1;
        phase_d   = phase_cur;
      end else begin
        byte_d = esc_q ? (src ^ EscapeXor) : src;
        esc_d  = 1'b0;
        unique case (phase_cur)
          PH_OPEN: phase_d = PH_DATA;
          PH_DATA: begin
            if (ent_i.last) begin
              phase_d = PH_CRC_LO;
            end else begin
              phase_d = PH_START;
              last_d  = 1'b1;
              pop_o   = 1'b1;
            end
          end
          PH_CRC_LO: phase_d = PH_CRC_HI;
          PH_CRC_HI: phase_d = PH_CLOSE;
          PH_CLOSE: begin
            byte_d  = FlagByte;
            phase_d = PH_START;
            last_d  = 1'b1;
            done_d  = 1'b1;
            pop_o   = 1'b1;
          end
          default: phase_d = PH_START;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q <= byte_d;
      last_q <= last_d;
      done_q <= done_d;
    end
  end

endmodule

// ----- rtl/hdlc_async_frame_encoder_crc16_top.sv -----
// top level of the hdlc async frame encoder with crc-16/ccitt-false
// instantiates hdlcenc_front, hdlcenc_queue and hdlcenc_back; uses hdlcenc_pkg
//
// Frames enter one byte per transfer, the last byte marked by end_of_frame_i,
// and leave as an HDLC-style byte stream: opening flag 0x7E, data with 0x7E
// and 0x7D escaped as 0x7D followed by the byte xor 0x20, the CRC-16 (poly
// 0x1021, init 0xFFFF) low byte first and escaped, then the closing flag with
// frame_done_o set; run_last_o marks the last line byte caused by each input
// byte. The back-end sequencer sends one line byte per cycle while its output
// register is free or popped; an input byte yields one line byte, plus an
// escape byte if stuffed, the opening flag if it opens a frame, and the CRC
// and closing flag if it ends one. A queue of QueueDepth entries sits between
// intake and sequencer, so input keeps flowing while results wait.
module hdlc_async_frame_encoder_crc16_top import hdlcenc_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_frame_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] line_byte_o,
  output logic       run_last_o,
  output logic       frame_done_o
);

  ent_t front_ent;
  ent_t head_ent;
  logic head_valid;
  logic head_pop;
  logic accept;

  assign accept = push && !full;

  hdlcenc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .ent_o          (front_ent)
  );

  hdlcenc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (front_ent),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .ent_o   (head_ent)
  );

  hdlcenc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (head_valid),
    .ent_i        (head_ent),
    .pop_o        (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .line_byte_o  (line_byte_o),
    .run_last_o   (run_last_o),
    .frame_done_o (frame_done_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for hdlc_async_frame_encoder_crc16_top
// predicts the stuffed line stream with crc-16/ccitt-false; uses hdlcenc_pkg
module testbench;
  import hdlcenc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit    = 2000;
  localparam int ItemsPerPhase = 48;

  typedef struct {
    logic [7:0] data;
    logic       eof;
  } frame_byte_t;

  typedef struct {
    logic [7:0] line_val;
    logic       run_last;
    logic       frame_done;
  } line_rec_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       push           = 1'b0;
  logic       full;
  logic [7:0] data_byte_i    = 8'h00;
  logic       end_of_frame_i = 1'b0;
  logic       empty;
  logic       pop            = 1'b0;
  logic [7:0] line_byte_o;
  logic       run_last_o;
  logic       frame_done_o;

  frame_byte_t frame_bytes[$];   // bytes waiting to be driven
  line_rec_t   line_expect[$];   // line bytes predicted, oldest first
  line_rec_t   byte_run[$];      // line bytes caused by one input byte

  logic [15:0] frame_crc  = CrcInit;
  logic        frame_open = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int line_count     = 0;
  int quiet_cycles   = 0;

  hdlc_async_frame_encoder_crc16_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .empty          (empty),
    .pop            (pop),
    .line_byte_o    (line_byte_o),
    .run_last_o     (run_last_o),
    .frame_done_o   (frame_done_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // bit-serial crc, msb of the data first
  function automatic logic [15:0] crc_ccitt_next(input logic [15:0] acc, input logic [7:0] d);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb  = acc[15] ^ d[k];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ CrcPoly;
    end
    return acc;
  endfunction

  task automatic add_line(input logic [7:0] v, input logic done);
    line_rec_t r;
    r.line_val   = v;
    r.run_last   = 1'b0;
    r.frame_done = done;
    byte_run.push_back(r);
  endtask

  task automatic add_stuffed(input logic [7:0] v);
    if (v == FlagByte || v == EscapeByte) begin
      add_line(EscapeByte, 1'b0);
      add_line(v ^ EscapeXor, 1'b0);
    end else begin
      add_line(v, 1'b0);
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic eof);
    line_rec_t r;
    byte_run.delete();
    if (!frame_open) begin
      add_line(FlagByte, 1'b0);
      frame_open = 1'b1;
      frame_crc  = CrcInit;
    end
    frame_crc = crc_ccitt_next(frame_crc, b);
    add_stuffed(b);
    if (eof) begin
      add_stuffed(frame_crc[7:0]);
      add_stuffed(frame_crc[15:8]);
      add_line(FlagByte, 1'b1);
      frame_crc  = CrcInit;
      frame_open = 1'b0;
    end
    for (int i = 0; i < byte_run.size(); i++) begin
      r = byte_run[i];
      r.run_last = (i == byte_run.size() - 1);
      line_expect.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic add_item(input logic [7:0] d, input logic eof);
    frame_byte_t s;
    s.data = d;
    s.eof  = eof;
    frame_bytes.push_back(s);
  endtask

  // random frame content, biased toward the two bytes that need stuffing
  task automatic queue_frame(input int len);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(3) == 0) d = $urandom_range(1) ? FlagByte : EscapeByte;
      else d = 8'($urandom);
      add_item(d, i == len - 1);
    end
  endtask

  task automatic wait_drained;
    while (frame_bytes.size() != 0 || line_expect.size() != 0) @(posedge clk_i);
  endtask

  // driver: holds an item while full, otherwise offers the next one or idles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        encode_byte(data_byte_i, end_of_frame_i);
        void'(frame_bytes.pop_front());
      end
      if (!(push && full)) begin
        if (frame_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push           <= 1'b1;
          data_byte_i    <= frame_bytes[0].data;
          end_of_frame_i <= frame_bytes[0].eof;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each line byte transfer with the oldest prediction
  always @(posedge clk_i) begin
    line_rec_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (line_expect.size() == 0) begin
          report_mismatch($sformatf("line byte %0d unexpected: %h last=%b done=%b",
                                    line_count, line_byte_o, run_last_o, frame_done_o));
        end else begin
          e = line_expect.pop_front();
          if (line_byte_o !== e.line_val || run_last_o !== e.run_last ||
              frame_done_o !== e.frame_done)
            report_mismatch($sformatf(
              "line byte %0d: got %h last=%b done=%b, want %h last=%b done=%b",
              line_count, line_byte_o, run_last_o, frame_done_o,
              e.line_val, e.run_last, e.frame_done));
        end
        line_count++;
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] c;
    logic [7:0]  sel;
    logic        found;
    int          queued;
    int          len;

    // directed: one-byte frames (extremes, stuffed values), then one six-byte frame
    add_item(8'h00, 1'b1);
    add_item(8'hFF, 1'b1);
    add_item(FlagByte, 1'b1);
    add_item(EscapeByte, 1'b1);
    add_item(FlagByte, 1'b0);
    add_item(EscapeByte, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(FlagByte ^ EscapeXor, 1'b0);
    add_item(EscapeByte ^ EscapeXor, 1'b1);
    // two-byte frames whose crc low or high byte has to be stuffed
    for (int t = 0; t < 4; t++) begin
      found = 1'b0;
      for (int w = 0; w < 65536 && !found; w++) begin
        c   = crc_ccitt_next(crc_ccitt_next(CrcInit, w[15:8]), w[7:0]);
        sel = t[0] ? c[15:8] : c[7:0];
        if (sel == (t[1] ? EscapeByte : FlagByte)) begin
          found = 1'b1;
          add_item(w[15:8], 1'b0);
          add_item(w[7:0], 1'b1);
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // idling phases; the sender pauses at each boundary until all line bytes are out
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      queued = 0;
      while (queued < ItemsPerPhase) begin
        case ($urandom_range(9))
          0: len = $urandom_range(24, 13);
          1, 2, 3: len = $urandom_range(12, 5);
          default: len = $urandom_range(4, 1);
        endcase
        queue_frame(len);
        queued += len;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hdlcenc_pkg.sv
rtl/hdlcenc_front.sv
rtl/hdlcenc_queue.sv
rtl/hdlcenc_back.sv
rtl/hdlc_async_frame_encoder_crc16_top.sv
tb/sv/testbench.sv
